// ===== sv/median_filter_3x3_assert.svh =====
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== sv/mf3_pkg.sv =====
`timescale 1ns / 1ps

package mf3_pkg;

	// default longest row the line buffer holds
	localparam int unsigned MAX_WIDTH_DEF = 1024;

	localparam int unsigned PIX_W  = 8;
	localparam int unsigned MEM_W  = 2 * PIX_W;
	localparam int unsigned CFG_WB = 11;
	localparam int unsigned CFG_HB = 12;
	// row counters run one or two rows past the frame while flushing
	localparam int unsigned ROW_W  = 13;

	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	localparam logic [CFG_WB-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_HB-1:0] HEIGHT_RESET = 12'd480;

	// register select: word address bit of paddr
	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	// one window column, index 0 = top row
	typedef pix_t [2:0] col_t;
	// full window, index 0 = left (oldest) column
	typedef col_t [2:0] win_t;

	// control traveling alongside a window into the sorter
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

	// edge masks of the output position
	typedef struct packed {
		logic left;
		logic right;
		logic top;
		logic bottom;
	} edge_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

endpackage

// ===== sv/median_filter_3x3.sv =====
// 3x3 median filter for a raster stream of 8-bit grey pixels. One transaction
// is taken per clock unless pixel_stall holds it: the line buffer is a single
// memory with one read and one write per cycle, and the window and the sorting
// network are fully pipelined, so the block sustains one pixel per cycle while
// median_stall does not back up the pipeline. The transaction that completes a
// window passes stage 1, the sorter stages s2 to s4 and the output register,
// which presents its median. Outputs lag input by one row plus one pixel; after
// the last pixel of a frame send image_width + 1 flush transactions (mode 1, or
// any further transaction) to drain the frame. Border neighbors count as zero,
// last_of_frame marks the final median, and the frame counters restart after
// it. A mode 1 transaction inside a frame is taken and ignored. Width 0 acts as
// 1 and is clipped to MAX_WIDTH; height 0 acts as 1. Change the size registers
// only between frames. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "median_filter_3x3_assert.svh"

module median_filter_3x3 #(
	parameter int unsigned MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mf3_pkg::APB_AW-1:0]  paddr,
	input  logic [mf3_pkg::APB_DW-1:0]  pwdata,
	output logic [mf3_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        pixel_valid,
	output logic                        pixel_stall,
	input  logic                        mode,
	input  logic [7:0]                  pixel,
	output logic                        median_valid,
	input  logic                        median_stall,
	output logic [7:0]                  median_value,
	output logic                        last_of_frame
);

	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = (CW > mf3_pkg::CFG_WB) ? CW : mf3_pkg::CFG_WB;
	localparam int unsigned RW = mf3_pkg::ROW_W;

	logic [mf3_pkg::CFG_WB-1:0] width_q;
	logic [mf3_pkg::CFG_HB-1:0] height_q;
	logic [CW-1:0]              in_col_q, out_col_q;
	logic [RW-1:0]              in_row_q, out_row_q;

	logic [WW-1:0]              w_raw;
	logic [CW-1:0]              w_eff;
	logic [mf3_pkg::CFG_HB-1:0] h_eff;
	logic [RW-1:0]              h_ext;
	logic                       wrap0, flushing, drop, emit, ld1;
	logic [CW-1:0]              col0, col1;
	logic [RW-1:0]              row0, row1;
	logic [CW:0]                col_inc, oc_inc;
	logic                       col_wrap, oc_end, or_end, last_acc;
	mf3_pkg::pix_t              pix_in;
	mf3_pkg::edge_t             edge_acc;

	logic                       valid_s1, emit_s1, last_s1;
	mf3_pkg::pix_t              v_s1;
	logic [AW-1:0]              addr_s1;
	mf3_pkg::edge_t             edge_s1;
	logic                       s1_go;
	logic                       fwd_hit_q;
	logic [mf3_pkg::MEM_W-1:0]  fwd_data_q, rd_data, lines;

	mf3_pkg::col_t              col0_q, col1_q, col2_q, col_new;
	mf3_pkg::win_t              nb;
	mf3_pkg::tag_t              med_tag;
	logic                       med_ready;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf3_pkg::WIDTH_RESET;
			height_q <= mf3_pkg::HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			case (mf3_pkg::reg_idx_t'(paddr[2]))
				mf3_pkg::REG_WIDTH: begin
					width_q <= pwdata[mf3_pkg::CFG_WB-1:0];
				end
				mf3_pkg::REG_HEIGHT: begin
					height_q <= pwdata[mf3_pkg::CFG_HB-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (mf3_pkg::reg_idx_t'(paddr[2]))
			mf3_pkg::REG_WIDTH:  prdata = mf3_pkg::APB_DW'(width_q);
			mf3_pkg::REG_HEIGHT: prdata = mf3_pkg::APB_DW'(height_q);
			default:             prdata = '0;
		endcase
	end

	// effective frame size
	assign w_raw = WW'(width_q);
	assign w_eff = (width_q == '0) ? CW'(1) :
	               (w_raw > WW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(w_raw);
	assign h_eff = (height_q == '0) ? mf3_pkg::CFG_HB'(1) : height_q;
	assign h_ext = RW'(h_eff);

	// input position and flush decision
	assign wrap0    = in_col_q >= w_eff;
	assign col0     = wrap0 ? '0 : in_col_q;
	assign row0     = wrap0 ? in_row_q + RW'(1) : in_row_q;
	assign flushing = row0 >= h_ext;
	assign drop     = !flushing && mode;
	assign pix_in   = flushing ? '0 : pixel;
	assign emit     = (row0 > RW'(1)) || ((row0 == RW'(1)) && (col0 != '0));

	assign col_inc  = {1'b0, col0} + (CW+1)'(1);
	assign col_wrap = col_inc >= {1'b0, w_eff};
	assign col1     = col_wrap ? '0 : col_inc[CW-1:0];
	assign row1     = col_wrap ? row0 + RW'(1) : row0;

	// output position, border masks and end of frame
	assign oc_inc   = {1'b0, out_col_q} + (CW+1)'(1);
	assign oc_end   = oc_inc >= {1'b0, w_eff};
	assign or_end   = (out_row_q + RW'(1)) >= h_ext;
	assign last_acc = or_end && oc_end;

	assign edge_acc.left   = out_col_q == '0;
	assign edge_acc.right  = oc_end;
	assign edge_acc.top    = out_row_q == '0;
	assign edge_acc.bottom = or_end;

	// stage 1 stalls only while its item cannot move on
	assign s1_go       = valid_s1 && (!emit_s1 || med_ready);
	assign pixel_stall = valid_s1 && !s1_go;
	assign ld1         = pixel_valid && !pixel_stall && !drop;

	// frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (ld1) begin
			if (emit && last_acc) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= col1;
				in_row_q <= row1;
				if (emit) begin
					if (oc_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + RW'(1);
					end else begin
						out_col_q <= oc_inc[CW-1:0];
					end
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (ld1) begin
				valid_s1  <= 1'b1;
				fwd_hit_q <= s1_go && (addr_s1 == col0[AW-1:0]);
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// stage 1 payload; bypass covers a write and read of one column on one edge
	always_ff @(posedge clk) begin
		if (ld1) begin
			v_s1       <= pix_in;
			emit_s1    <= emit;
			last_s1    <= last_acc;
			addr_s1    <= col0[AW-1:0];
			edge_s1    <= edge_acc;
			fwd_data_q <= {lines[mf3_pkg::PIX_W-1:0], v_s1};
		end
	end

	mf3_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (ld1),
		.rd_addr (col0[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (s1_go),
		.wr_addr (addr_s1),
		.wr_data ({lines[mf3_pkg::PIX_W-1:0], v_s1})
	);

	assign lines = fwd_hit_q ? fwd_data_q : rd_data;

	// new right column: upper line, middle line, current pixel
	assign col_new[0] = lines[mf3_pkg::MEM_W-1:mf3_pkg::PIX_W];
	assign col_new[1] = lines[mf3_pkg::PIX_W-1:0];
	assign col_new[2] = v_s1;

	mf3_col_cell u_cell2 (.clk(clk), .arst_n(arst_n), .en(s1_go), .d(col_new), .q(col2_q));
	mf3_col_cell u_cell1 (.clk(clk), .arst_n(arst_n), .en(s1_go), .d(col2_q),  .q(col1_q));
	mf3_col_cell u_cell0 (.clk(clk), .arst_n(arst_n), .en(s1_go), .d(col1_q),  .q(col0_q));

	// window after the shift, borders forced to zero
	always_comb begin
		nb[0] = col1_q;
		nb[1] = col2_q;
		nb[2] = col_new;
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				if ((j == 0 && edge_s1.left) || (j == 2 && edge_s1.right) ||
				    (k == 0 && edge_s1.top) || (k == 2 && edge_s1.bottom)) begin
					nb[j][k] = '0;
				end
			end
		end
	end

	assign med_tag.valid = s1_go && emit_s1;
	assign med_tag.last  = last_s1;

	mf3_median u_median (
		.clk           (clk),
		.arst_n        (arst_n),
		.nb            (nb),
		.tag_in        (med_tag),
		.ready         (med_ready),
		.median_value  (median_value),
		.last_of_frame (last_of_frame),
		.median_valid  (median_valid),
		.median_stall  (median_stall)
	);

	// checks
	`MF3_ASSERT_NEXT(a_last_restart, ld1 && emit && last_acc,
		in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0,
		"frame counters did not restart after the last output")
	`MF3_ASSERT_NOW(a_stall_cause, pixel_stall, valid_s1 && emit_s1 && !med_ready,
		"input stalled without a blocked emitting item in stage 1")
	`MF3_ASSERT_NEXT(a_window_hold, !s1_go, $stable(col2_q) && $stable(col0_q),
		"window moved without an item leaving stage 1")

endmodule

// ===== sv/mf3_line_buf.sv =====
`timescale 1ns / 1ps

module mf3_line_buf #(
	parameter int unsigned DEPTH = mf3_pkg::MAX_WIDTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [mf3_pkg::MEM_W-1:0]  rd_data,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [mf3_pkg::MEM_W-1:0]  wr_data
);

	// two stacked lines per word: [15:8] upper line, [7:0] middle line
	logic [mf3_pkg::MEM_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/mf3_col_cell.sv =====
`timescale 1ns / 1ps

module mf3_col_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  mf3_pkg::col_t d,
	output mf3_pkg::col_t q
);

	// one window column; takes its neighbor's column on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= d;
		end
	end

endmodule

// ===== sv/mf3_median.sv =====
`timescale 1ns / 1ps

module mf3_median (
	input  logic          clk,
	input  logic          arst_n,
	input  mf3_pkg::win_t nb,
	input  mf3_pkg::tag_t tag_in,
	output logic          ready,
	output mf3_pkg::pix_t median_value,
	output logic          last_of_frame,
	output logic          median_valid,
	input  logic          median_stall
);

	mf3_pkg::tag_t tag_s2, tag_s3, tag_s4;
	mf3_pkg::win_t nb_s2;
	mf3_pkg::col_t lo_s3, md_s3, hi_s3;
	mf3_pkg::pix_t a_s4, b_s4, c_s4;
	mf3_pkg::pix_t med_q;
	logic          last_q, valid_q;
	logic          rdy_out, rdy4, rdy3, rdy2;

	// stage moves when empty or when the next one moves
	assign rdy_out = !valid_q || !median_stall;
	assign rdy4    = !tag_s4.valid || rdy_out;
	assign rdy3    = !tag_s3.valid || rdy4;
	assign rdy2    = !tag_s2.valid || rdy3;
	assign ready   = rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2  <= '0;
			tag_s3  <= '0;
			tag_s4  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (rdy2) tag_s2 <= tag_in;
			if (rdy3) tag_s3 <= tag_s2;
			if (rdy4) tag_s4 <= tag_s3;
			if (rdy_out) valid_q <= tag_s4.valid;
		end
	end

	// s2 holds the masked window; s3 sorts each column;
	// s4 takes max of lows, median of mids, min of highs; output is their median
	always_ff @(posedge clk) begin
		if (rdy2 && tag_in.valid) begin
			nb_s2 <= nb;
		end
		if (rdy3 && tag_s2.valid) begin
			for (int j = 0; j < 3; j++) begin
				lo_s3[j] <= mf3_pkg::min2(mf3_pkg::min2(nb_s2[j][0], nb_s2[j][1]), nb_s2[j][2]);
				md_s3[j] <= mf3_pkg::med3(nb_s2[j][0], nb_s2[j][1], nb_s2[j][2]);
				hi_s3[j] <= mf3_pkg::max2(mf3_pkg::max2(nb_s2[j][0], nb_s2[j][1]), nb_s2[j][2]);
			end
		end
		if (rdy4 && tag_s3.valid) begin
			a_s4 <= mf3_pkg::max2(mf3_pkg::max2(lo_s3[0], lo_s3[1]), lo_s3[2]);
			b_s4 <= mf3_pkg::med3(md_s3[0], md_s3[1], md_s3[2]);
			c_s4 <= mf3_pkg::min2(mf3_pkg::min2(hi_s3[0], hi_s3[1]), hi_s3[2]);
		end
		if (rdy_out && tag_s4.valid) begin
			med_q  <= mf3_pkg::med3(a_s4, b_s4, c_s4);
			last_q <= tag_s4.last;
		end
	end

	assign median_value  = med_q;
	assign last_of_frame = last_q;
	assign median_valid  = valid_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int unsigned MAXW = mf3_pkg::MAX_WIDTH_DEF;
	localparam int unsigned AWB = mf3_pkg::APB_AW;
	localparam int unsigned DWB = mf3_pkg::APB_DW;
	localparam int unsigned WB = mf3_pkg::CFG_WB;
	localparam int unsigned HB = mf3_pkg::CFG_HB;
	// cycles allowed for the pipeline to settle before a register write
	localparam int LAT_HOLD = 12;
	// cycles with no transaction on any port before the run is abandoned
	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_PIXELS = 450;

	localparam logic [AWB-1:0] ADDR_WIDTH  = {mf3_pkg::REG_WIDTH, 2'b00};
	localparam logic [AWB-1:0] ADDR_HEIGHT = {mf3_pkg::REG_HEIGHT, 2'b00};

	typedef mf3_pkg::pix_t [8:0] nine_t;

	typedef struct packed {
		mf3_pkg::pix_t value;
		logic          last;
	} median_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_EVERY_THIRD
	} stall_style_t;

	logic           clk;
	logic           arst_n = 1'b0;
	logic           psel = 1'b0;
	logic           penable = 1'b0;
	logic           pwrite = 1'b0;
	logic [AWB-1:0] paddr = '0;
	logic [DWB-1:0] pwdata = '0;
	logic [DWB-1:0] prdata;
	logic           pready;
	logic           pixel_valid = 1'b0;
	logic           pixel_stall;
	logic           mode = 1'b0;
	logic [7:0]     pixel = '0;
	logic           median_valid;
	logic           median_stall = 1'b0;
	logic [7:0]     median_value;
	logic           last_of_frame;

	// filter state mirrored by the bench
	logic [WB-1:0]     cfg_width = mf3_pkg::WIDTH_RESET;
	logic [HB-1:0]     cfg_height = mf3_pkg::HEIGHT_RESET;
	mf3_pkg::pix_t     line_mem [0:2*MAXW-1];
	nine_t             win = '0;
	int unsigned       in_col = 0;
	int unsigned       in_row = 0;
	int unsigned       out_col = 0;
	int unsigned       out_row = 0;
	median_t           pending_medians [$];

	// bookkeeping
	int          errors = 0;
	int unsigned items_sent = 0;
	int unsigned pixels_taken = 0;
	int unsigned medians_checked = 0;
	int unsigned frames_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned quiet_cycles = 0;
	int          burst_left = 0;
	int          gap_max = 4;
	int          style_left = 0;
	stall_style_t stall_style = STALL_NONE;

	median_filter_3x3 DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.pixel_valid   (pixel_valid),
		.pixel_stall   (pixel_stall),
		.mode          (mode),
		.pixel         (pixel),
		.median_valid  (median_valid),
		.median_stall  (median_stall),
		.median_value  (median_value),
		.last_of_frame (last_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic int unsigned used_width();
		if (cfg_width == 0)
			return 1;
		if (cfg_width > MAXW)
			return MAXW;
		return cfg_width;
	endfunction

	function automatic int unsigned used_height();
		return (cfg_height == 0) ? 1 : cfg_height;
	endfunction

	function automatic mf3_pkg::pix_t median_of_nine(input nine_t vals);
		nine_t         s;
		mf3_pkg::pix_t t;
		int            i, j;
		s = vals;
		for (i = 0; i < 8; i++)
			for (j = 0; j < 8 - i; j++)
				if (s[j] > s[j+1]) begin
					t = s[j];
					s[j] = s[j+1];
					s[j+1] = t;
				end
		return s[4];
	endfunction

	// Advance the mirrored filter by one accepted transaction; queue a median if one is due
	task automatic advance_filter(input logic m, input mf3_pkg::pix_t p, output logic taken);
		int unsigned   w, h, c;
		int            k;
		logic          flushing, emit, last;
		mf3_pkg::pix_t top, mid, v;
		nine_t         nb;
		median_t       r;
		w = used_width();
		h = used_height();
		taken = 1'b0;
		// counters may sit past a row end after a resize
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		flushing = (in_row >= h);
		// flush request inside the frame is dropped
		if (!flushing && m)
			return;
		taken = 1'b1;
		v = flushing ? 8'd0 : p;
		emit = (in_row > 1) || (in_row == 1 && in_col >= 1);

		// line buffers: top row out, middle moves up, new pixel in
		c = in_col;
		top = line_mem[c];
		mid = line_mem[MAXW + c];
		line_mem[c] = mid;
		line_mem[MAXW + c] = v;
		for (k = 0; k < 3; k++) begin
			win[k*3] = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = v;

		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (!emit)
			return;

		// zero the neighbors that fall outside the image
		nb = win;
		for (k = 0; k < 3; k++) begin
			if (out_col == 0)
				nb[k*3] = '0;
			if (out_col + 1 >= w)
				nb[k*3+2] = '0;
			if (out_row == 0)
				nb[k] = '0;
			if (out_row + 1 >= h)
				nb[6+k] = '0;
		end
		last = (out_row + 1 >= h) && (out_col + 1 >= w);
		r.value = median_of_nine(nb);
		r.last = last;
		pending_medians.push_back(r);

		if (last) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
	endtask

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		median_t exp_m;
		if (arst_n && median_valid && !median_stall) begin
			if (pending_medians.size() == 0) begin
				errors++;
				$error("median_value: expected none, got %0d", median_value);
			end else begin
				exp_m = pending_medians.pop_front();
				medians_checked++;
				if (median_value !== exp_m.value) begin
					errors++;
					$error("median_value: expected %0d, got %0d", exp_m.value, median_value);
				end
				if (last_of_frame !== exp_m.last) begin
					errors++;
					$error("last_of_frame: expected %0d, got %0d", exp_m.last, last_of_frame);
				end
			end
			if (last_of_frame === 1'b1)
				frames_seen++;
		end
	end

	// Receiver stall pattern in one of four randomly chosen styles
	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 3));
			style_left = $urandom_range(50, 300);
		end
		style_left--;
		case (stall_style)
			STALL_NONE:  median_stall <= 1'b0;
			STALL_LIGHT: median_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: median_stall <= ($urandom_range(0, 3) != 0);
			default:     median_stall <= (style_left % 3 == 0);
		endcase
	end

	// Watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && !pixel_stall) || (median_valid && !median_stall) ||
				(psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL median_filter_3x3");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	function automatic mf3_pkg::pix_t rand_pixel();
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return mf3_pkg::pix_t'($urandom_range(100, 103));
			default: return mf3_pkg::pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	// One pixel transaction; the sender idles between bursts
	task automatic push_pixel(input logic m, input mf3_pkg::pix_t p);
		logic taken;
		int   gap;
		mode <= m;
		pixel <= p;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_stall);
		advance_filter(m, p, taken);
		items_sent++;
		if (taken)
			pixels_taken++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			if (gap_max > 0) begin
				gap = $urandom_range(1, gap_max);
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Hold input until every queued median is out, then let the pipeline settle
	task automatic wait_for_medians();
		pixel_valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (LAT_HOLD) @(posedge clk);
	endtask

	task automatic apb_write(input logic [AWB-1:0] addr, input logic [DWB-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [AWB-1:0] addr, output logic [DWB-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_regs();
		logic [DWB-1:0] rd;
		apb_read(ADDR_WIDTH, rd);
		if (rd !== {{(DWB-WB){1'b0}}, cfg_width}) begin
			errors++;
			$error("image_width: expected %0d, got %0d", cfg_width, rd);
		end
		apb_read(ADDR_HEIGHT, rd);
		if (rd !== {{(DWB-HB){1'b0}}, cfg_height}) begin
			errors++;
			$error("image_height: expected %0d, got %0d", cfg_height, rd);
		end
	endtask

	task automatic set_size(input logic [DWB-1:0] wdata, input logic [DWB-1:0] hdata);
		wait_for_medians();
		apb_write(ADDR_WIDTH, wdata);
		cfg_width = wdata[WB-1:0];
		apb_write(ADDR_HEIGHT, hdata);
		cfg_height = hdata[HB-1:0];
		reg_writes += 2;
		check_regs();
	endtask

	// Full frame at the current size, then width + 1 flush transactions
	task automatic send_frame(input bit noisy);
		int unsigned w, h, n, pause_at, i;
		w = used_width();
		h = used_height();
		n = w * h;
		pause_at = (noisy && $urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
		for (i = 0; i < n; i++) begin
			if (i == pause_at)
				wait_for_medians();
			if (noisy && $urandom_range(0, 15) == 0)
				push_pixel(1'b1, rand_pixel());
			push_pixel(1'b0, rand_pixel());
		end
		// mode 0 past the frame end drains just like mode 1
		for (i = 0; i <= w; i++)
			push_pixel(1'($urandom_range(0, 1)), rand_pixel());
	endtask

	// Push pixels until the frame in progress has closed
	task automatic finish_frame();
		while (!(in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0))
			push_pixel(1'b0, rand_pixel());
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	task automatic test_reset_values();
		check_regs();
	endtask

	// 3x3 frame: extreme pixels, a dropped flush inside the frame, mixed flush modes
	task automatic test_small_frame();
		set_size(3, 3);
		push_pixel(1'b0, 8'd0);
		push_pixel(1'b0, 8'd255);
		push_pixel(1'b0, 8'd0);
		push_pixel(1'b0, 8'd255);
		push_pixel(1'b1, 8'd255);
		push_pixel(1'b0, 8'd128);
		push_pixel(1'b0, 8'd255);
		push_pixel(1'b0, 8'hAA);
		push_pixel(1'b0, 8'h55);
		push_pixel(1'b0, 8'hFF);
		push_pixel(1'b0, 8'h00);
		push_pixel(1'b1, 8'h00);
		push_pixel(1'b0, 8'hFF);
		push_pixel(1'b1, 8'hFF);
	endtask

	// zero sizes act as a single pixel frame
	task automatic test_single_pixel_frame();
		set_size(0, 0);
		push_pixel(1'b0, 8'h5A);
		push_pixel(1'b1, 8'h00);
		push_pixel(1'b0, 8'hA5);
	endtask

	// all-ones size writes read back masked to the fields, then a frame of wide rows
	task automatic test_wide_rows();
		gap_max = 3;
		set_size(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		set_size(64, 2);
		send_frame(1'b1);
	endtask

	// one pixel per row, tall frame, full input rate
	task automatic test_tall_column();
		gap_max = 0;
		set_size(1, 60);
		send_frame(1'b0);
		gap_max = 4;
	endtask

	// Shrink the width in the middle of a frame. The previous full frame wrote
	// every column below the new width, so no unwritten buffer entry is read.
	task automatic test_resize_mid_frame();
		set_size(16, 6);
		send_frame(1'b0);
		repeat (2 * 16 + 11) push_pixel(1'b0, rand_pixel());
		set_size(8, 2);
		finish_frame();
	endtask

	task automatic test_random_frames();
		int unsigned start, w, h;
		start = pixels_taken;
		while (pixels_taken - start < RANDOM_PIXELS) begin
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					0:       w = $urandom_range(0, 2);
					1:       w = $urandom_range(13, 40);
					default: w = $urandom_range(3, 12);
				endcase
				h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
				// upper pwdata bits are outside the fields
				set_size(($urandom() << 12) | w, ($urandom() << 12) | h);
			end
			send_frame(1'b1);
			// occasionally a stray or cut-off sequence, closed by extra pixels
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 6))
					push_pixel(1'($urandom_range(0, 1)), rand_pixel());
				finish_frame();
			end
		end
	endtask

	initial begin
		foreach (line_mem[i])
			line_mem[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_small_frame();
		test_single_pixel_frame();
		test_wide_rows();
		test_tall_column();
		test_resize_mid_frame();
		test_random_frames();
		wait_for_medians();

		$display("Covered %0d pixel transactions (%0d used), %0d medians in %0d frames,",
			items_sent, pixels_taken, medians_checked, frames_seen);
		$display("%0d size register writes incl. zero and all-ones values.", reg_writes);
		if (errors == 0)
			$display("PASS median_filter_3x3");
		else
			$display("FAIL median_filter_3x3");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mf3_pkg.sv
sv/mf3_line_buf.sv
sv/mf3_col_cell.sv
sv/mf3_median.sv
sv/median_filter_3x3.sv
bench/tb.sv
